/* rtl/tre_pkg.sv */
// Package with the shared types and constants of the RTT estimator.
`timescale 1ns / 1ps
`default_nettype none

package tre_pkg;

    localparam int RTO_W    = 26;
    localparam int EST_W    = 31;
    localparam int SAMPLE_W = 32;
    localparam int CMD_W    = 2;

    localparam logic [EST_W-1:0] EST_SAT     = 31'h7FFF_FFFF;
    localparam logic [RTO_W-1:0] FLOOR_RESET = 26'd200000;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_RESET  = 2'd1,
        CMD_SEED   = 2'd2
    } cmd_t;

    typedef logic [RTO_W-1:0]    rto_t;
    typedef logic [EST_W-1:0]    est_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

/* rtl/tre_cmd_if.sv */
// Channel that carries one estimator command per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface tre_cmd_if;
    import tre_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic signed [SAMPLE_W-1:0] rtt_sample_us;

    modport source (output valid, output cmd, output rtt_sample_us, input ready);
    modport sink   (input valid, input cmd, input rtt_sample_us, output ready);
endinterface

`default_nettype wire

/* rtl/tre_res_if.sv */
// Channel that carries the estimator state after each command.
`timescale 1ns / 1ps
`default_nettype none

interface tre_res_if;
    import tre_pkg::*;

    logic             valid;
    logic             ready;
    logic [RTO_W-1:0] rto_us;
    logic [EST_W-1:0] srtt_x8;
    logic [EST_W-1:0] rttvar_x4;

    modport source (output valid, output rto_us, output srtt_x8, output rttvar_x4,
                    input ready);
    modport sink   (input valid, input rto_us, input srtt_x8, input rttvar_x4,
                    output ready);
endinterface

`default_nettype wire

/* rtl/tre_cfg_if.sv */
// Write channel for the RTO floor register.
`timescale 1ns / 1ps
`default_nettype none

interface tre_cfg_if;
    import tre_pkg::*;

    logic             valid;
    logic             ready;
    logic [RTO_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tcp_rtt_estimator_rto_top.sv */
// Top level of the per-connection TCP RTT estimator and RTO calculator.
`timescale 1ns / 1ps
`default_nettype none

// Retransmission-timeout estimator for one connection. Each command transfer
// (sample update, estimator reset or handshake seed) yields exactly one result
// transfer holding the RTO, the smoothed RTT times eight and the variance times
// four after that command. A command is captured in an input register and applied,
// updating the estimator state registers (also the result register), once no result
// is pending or the pending one is taken; one command is taken every cycle while
// results are taken. The floor register is written through the cfg channel,
// clamped to 1..MAX_RTO, and does not recompute the stored RTO.
module tcp_rtt_estimator_rto_top #(
    parameter int MAX_RTO_US     = 60000000,
    parameter int INITIAL_RTO_US = 1000000
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tre_cmd_if.sink   rtt_in,
    tre_res_if.source rto_out,
    tre_cfg_if.sink   cfg
);
    import tre_pkg::*;

    localparam rto_t MAX_RTO  = RTO_W'(MAX_RTO_US);
    localparam est_t INIT_VAR = EST_W'(INITIAL_RTO_US);
    localparam int   RTO_RESET_I =
        (INITIAL_RTO_US < int'(FLOOR_RESET)) ? int'(FLOOR_RESET) :
        ((INITIAL_RTO_US > MAX_RTO_US) ? MAX_RTO_US : INITIAL_RTO_US);
    localparam rto_t RTO_RESET = RTO_W'(RTO_RESET_I);

    function automatic rto_t clamp_rto(input logic [31:0] v, input rto_t fl);
        rto_t r;
        if (v < {6'd0, fl})
        begin
            r = fl;
        end
        else if (v > {6'd0, MAX_RTO})
        begin
            r = MAX_RTO;
        end
        else
        begin
            r = v[RTO_W-1:0];
        end
        return r;
    endfunction

    function automatic est_t clamp_est(input logic signed [33:0] v);
        est_t r;
        if (v < 34'sd1)
        begin
            r = est_t'(1);
        end
        else if (v > $signed({3'd0, EST_SAT}))
        begin
            r = EST_SAT;
        end
        else
        begin
            r = v[EST_W-1:0];
        end
        return r;
    endfunction

    logic                       s1_valid_reg;
    logic [CMD_W-1:0]           s1_cmd_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       out_valid_reg;
    est_t                       srtt_reg;
    est_t                       srtt_next;
    est_t                       var_reg;
    est_t                       var_next;
    rto_t                       rto_reg;
    rto_t                       rto_next;
    rto_t                       floor_reg;
    rto_t                       floor_next;
    logic                       advance;
    rto_t                       m;

    assign advance       = s1_valid_reg && (!out_valid_reg || rto_out.ready);
    assign rtt_in.ready  = !s1_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    assign rto_out.valid     = out_valid_reg;
    assign rto_out.rto_us    = rto_reg;
    assign rto_out.srtt_x8   = srtt_reg;
    assign rto_out.rttvar_x4 = var_reg;

    always_comb
    begin
        if (s1_sample_reg <= 32'sd0)
        begin
            m = rto_t'(1);
        end
        else if (s1_sample_reg > $signed({6'd0, MAX_RTO}))
        begin
            m = MAX_RTO;
        end
        else
        begin
            m = s1_sample_reg[RTO_W-1:0];
        end
    end

    always_comb
    begin
        if (cfg.data == '0)
        begin
            floor_next = rto_t'(1);
        end
        else if (cfg.data > MAX_RTO)
        begin
            floor_next = MAX_RTO;
        end
        else
        begin
            floor_next = cfg.data;
        end
    end

    always_comb
    begin
        logic signed [32:0] err;
        logic signed [32:0] mag;
        logic signed [33:0] sa;
        logic signed [33:0] sv;
        est_t               var_eff;
        logic [31:0]        sum;
        logic [31:0]        m3;

        err = $signed({7'd0, m}) - $signed({5'd0, srtt_reg[EST_W-1:3]});
        mag = (err < 33'sd0) ? -err : err;
        sa  = $signed({3'd0, srtt_reg}) + {err[32], err};
        sv  = $signed({3'd0, var_reg}) + {mag[32], mag} - $signed({5'd0, var_reg[EST_W-1:2]});
        m3  = ({6'd0, m} << 1) + {6'd0, m};
        var_eff = '0;
        sum     = '0;

        srtt_next = srtt_reg;
        var_next  = var_reg;
        rto_next  = rto_reg;

        unique case (s1_cmd_reg)
            CMD_RESET:
            begin
                srtt_next = '0;
                var_next  = INIT_VAR;
                rto_next  = clamp_rto(32'(INITIAL_RTO_US), floor_reg);
            end
            CMD_SEED:
            begin
                rto_next = clamp_rto(m3, floor_reg);
            end
            CMD_SAMPLE:
            begin
                if (srtt_reg == '0)
                begin
                    srtt_next = {2'd0, m, 3'd0};
                    if (var_reg <= INIT_VAR)
                    begin
                        var_next = {4'd0, m, 1'b0};
                    end
                end
                else
                begin
                    srtt_next = clamp_est(sa);
                    var_next  = clamp_est(sv);
                end
                var_eff  = (var_next < {5'd0, floor_reg}) ? {5'd0, floor_reg} : var_next;
                sum      = {4'd0, srtt_next[EST_W-1:3]} + {1'b0, var_eff};
                rto_next = clamp_rto(sum, floor_reg);
            end
            default:
            begin
                rto_next = rto_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            srtt_reg      <= '0;
            var_reg       <= INIT_VAR;
            rto_reg       <= RTO_RESET;
            floor_reg     <= FLOOR_RESET;
        end
        else
        begin
            if (rtt_in.ready)
            begin
                s1_valid_reg <= rtt_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                srtt_reg      <= srtt_next;
                var_reg       <= var_next;
                rto_reg       <= rto_next;
            end
            else if (rto_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                floor_reg <= floor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rtt_in.valid && rtt_in.ready)
        begin
            s1_cmd_reg    <= rtt_in.cmd;
            s1_sample_reg <= rtt_in.rtt_sample_us;
        end
    end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for the TCP RTT estimator and RTO calculator with a self-checking scoreboard.
`timescale 1ns / 1ps

module tb;
    import tre_pkg::*;

    localparam int MAX_RTO       = 60000000;
    localparam int INITIAL_RTO   = 1000000;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int HOLD_CYCLES   = 60;
    localparam int ITEMS_PER_SET = 160;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        rto_t rto;
        est_t srtt;
        est_t rttvar;
    } estimate_t;

    class rto_tracker;
        longint floor_value;
        longint srtt_x8;
        longint rttvar_x4;
        longint timeout_us;
        int mismatches;
        estimate_t pending_estimates[$];

        function new();
            floor_value = longint'(FLOOR_RESET);
            mismatches = 0;
            restart();
        endfunction

        function longint clamp_timeout(longint v);
            if (v < floor_value)
                return floor_value;
            if (v > MAX_RTO)
                return MAX_RTO;
            return v;
        endfunction

        function longint clamp_est(longint v);
            if (v < 1)
                return 1;
            if (v > longint'(EST_SAT))
                return longint'(EST_SAT);
            return v;
        endfunction

        function void restart();
            srtt_x8 = 0;
            rttvar_x4 = INITIAL_RTO;
            timeout_us = clamp_timeout(INITIAL_RTO);
        endfunction

        function void set_floor(rto_t d);
            longint v;
            v = longint'(d);
            if (v < 1)
                v = 1;
            else if (v > MAX_RTO)
                v = MAX_RTO;
            floor_value = v;
        endfunction

        function void take_command(logic [CMD_W-1:0] c, logic signed [SAMPLE_W-1:0] raw);
            longint m;
            longint err;
            longint mag;
            longint var_floor;
            estimate_t e;
            m = longint'(raw);
            if (m <= 0)
                m = 1;
            else if (m > MAX_RTO)
                m = MAX_RTO;
            case (c)
                CMD_RESET:
                begin
                    restart();
                end
                CMD_SEED:
                begin
                    timeout_us = clamp_timeout(3 * m);
                end
                CMD_SAMPLE:
                begin
                    if (srtt_x8 == 0)
                    begin
                        srtt_x8 = clamp_est(m * 8);
                        if (rttvar_x4 <= INITIAL_RTO)
                            rttvar_x4 = clamp_est(m * 2);
                    end
                    else
                    begin
                        err = m - (srtt_x8 >>> 3);
                        mag = (err < 0) ? -err : err;
                        srtt_x8 = clamp_est(srtt_x8 + err);
                        rttvar_x4 = clamp_est(rttvar_x4 + (mag - (rttvar_x4 >>> 2)));
                    end
                    var_floor = (rttvar_x4 < floor_value) ? floor_value : rttvar_x4;
                    timeout_us = clamp_timeout((srtt_x8 >>> 3) + var_floor);
                end
                default:
                begin
                end
            endcase
            e.rto = rto_t'(timeout_us);
            e.srtt = est_t'(srtt_x8);
            e.rttvar = est_t'(rttvar_x4);
            pending_estimates.push_back(e);
        endfunction

        function void report(string field, longint exp_v, longint act_v);
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
        endfunction

        function void check_estimate(rto_t r, est_t s, est_t v);
            estimate_t e;
            if (pending_estimates.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual %0d %0d %0d",
                         $time, r, s, v);
                return;
            end
            e = pending_estimates.pop_front();
            if (r !== e.rto)
                report("rto_us", e.rto, r);
            if (s !== e.srtt)
                report("srtt_x8", e.srtt, s);
            if (v !== e.rttvar)
                report("rttvar_x4", e.rttvar, v);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tre_cmd_if cmd_ch ();
    tre_res_if res_ch ();
    tre_cfg_if cfg_ch ();

    tcp_rtt_estimator_rto_top #(
        .MAX_RTO_US     (MAX_RTO),
        .INITIAL_RTO_US (INITIAL_RTO)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rtt_in  (cmd_ch),
        .rto_out (res_ch),
        .cfg     (cfg_ch)
    );

    rto_tracker tracker = new();

    int send_idle = 0;
    int recv_idle = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int quiet_cycles = 0;
    longint base_rtt = 50000;

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Every transfer is observed at the clock edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
                tracker.check_estimate(res_ch.rto_us, res_ch.srtt_x8, res_ch.rttvar_x4);
            if (cmd_ch.valid && cmd_ch.ready)
                tracker.take_command(cmd_ch.cmd, cmd_ch.rtt_sample_us);
            if (cfg_ch.valid && cfg_ch.ready)
                tracker.set_floor(cfg_ch.data);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] c, input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= c;
        cmd_ch.rtt_sample_us <= s;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (tracker.pending_estimates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_floor(input rto_t v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        longint lo;
        longint hi;
        r = $urandom_range(99);
        if (r < 70)
        begin
            lo = base_rtt / 2;
            hi = base_rtt + base_rtt / 2 + 1;
            return $urandom_range(hi, lo);
        end
        else if (r < 76)
            return $urandom_range(10, 0);
        else if (r < 82)
            return $urandom_range(MAX_RTO + 20, MAX_RTO - 20);
        else if (r < 92)
            return $urandom;
        else
            return SAMPLE_W'(-$signed({1'b0, $urandom_range(32'h7FFF_FFFF, 0)})
                             - $urandom_range(1, 0));
    endfunction

    function automatic void pick_base();
        case ($urandom_range(2))
            0: base_rtt = longint'($urandom_range(1000, 1));
            1: base_rtt = longint'($urandom_range(100000, 1000));
            default: base_rtt = longint'($urandom_range(20000000, 100000));
        endcase
    endfunction

    task automatic random_items(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 5)
            begin
                pick_base();
                send_command(CMD_RESET, $urandom);
            end
            else if (r < 13)
                send_command(CMD_SEED, pick_sample());
            else
                send_command(CMD_SAMPLE, pick_sample());
            if (i == 20 && (count & 1) == 0)
                hold_requests++;
        end
    endtask

    initial
    begin
        rto_t floor_set[8];
        int mode;

        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.cmd <= CMD_SAMPLE;
        cmd_ch.rtt_sample_us <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_SAMPLE, 1000);
        send_command(CMD_SAMPLE, 0);
        send_command(CMD_SAMPLE, 32'sh8000_0000);
        send_command(CMD_SAMPLE, 32'sh7FFF_FFFF);
        send_command(CMD_SAMPLE, MAX_RTO);
        send_command(CMD_SAMPLE, MAX_RTO + 1);
        send_command(CMD_SEED, 1);
        send_command(CMD_SEED, 32'sh7FFF_FFFF);
        send_command(CMD_SEED, -5);
        send_command(CMD_SEED, 30000);
        send_command(CMD_UNUSED, 32'sh5555_5555);
        send_command(CMD_RESET, 32'shAAAA_AAAA);
        send_command(CMD_UNUSED, 12345);
        send_command(CMD_SAMPLE, 500000);
        send_command(CMD_SAMPLE, 400000);
        send_command(CMD_SAMPLE, -1);
        send_command(CMD_RESET, 0);
        send_command(CMD_SEED, 100);
        send_command(CMD_SAMPLE, 1);
        send_command(CMD_SAMPLE, 32'sh7FFF_FFFF);
        send_command(CMD_SAMPLE, 1);

        floor_set[0] = 26'd1;
        floor_set[1] = rto_t'(MAX_RTO);
        floor_set[2] = 26'd0;
        floor_set[3] = 26'h3FF_FFFF;
        floor_set[4] = rto_t'($urandom_range(26'h3FF_FFFF, 0));
        floor_set[5] = FLOOR_RESET;
        floor_set[6] = rto_t'($urandom_range(2000, 1));
        floor_set[7] = rto_t'($urandom_range(MAX_RTO, 1));

        for (int k = 0; k < 8; k++)
        begin
            mode = k * 3 / 8;
            send_idle = (mode == 0) ? 15 : (mode == 1) ? 80 : 0;
            recv_idle = (mode == 0) ? 80 : (mode == 1) ? 15 : 0;
            write_floor(floor_set[k]);
            pick_base();
            send_command(CMD_RESET, $urandom);
            random_items(ITEMS_PER_SET + (k % 3 == 2 ? 0 : 1) - 1 + (k == 2 || k == 6 ? 0 : 1));
        end

        drain();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/tre_pkg.sv
rtl/tre_cmd_if.sv
rtl/tre_res_if.sv
rtl/tre_cfg_if.sv
rtl/tcp_rtt_estimator_rto_top.sv
verif/tb.sv
